// ----- hdl/lsct_pkg.sv -----
// Shared types and constants for the line sensor crossing tracker.
// No dependencies.
`timescale 1ns / 1ps

package lsct_pkg;

  localparam logic [2:0] CLS_NONE    = 3'd0;
  localparam logic [2:0] CLS_ELEM0   = 3'd1;
  localparam logic [2:0] CLS_ELEM1   = 3'd2;
  localparam logic [2:0] CLS_ELEM2   = 3'd3;
  localparam logic [2:0] CLS_ELEM3   = 3'd4;
  localparam logic [2:0] CLS_PRESSED = 3'd5;
  localparam logic [2:0] CLS_IGNORED = 3'd6;

  localparam logic [1:0] MOUNT_A = 2'd0;
  localparam logic [1:0] MOUNT_B = 2'd1;
  localparam logic [1:0] MOUNT_C = 2'd2;

  localparam logic signed [1:0] DIR_NEG  = -2'sd1;
  localparam logic signed [1:0] DIR_ZERO = 2'sd0;
  localparam logic signed [1:0] DIR_POS  = 2'sd1;

  localparam logic signed [3:0] ERR_FAR_NEG  = -4'sd4;
  localparam logic signed [3:0] ERR_NEAR_NEG = -4'sd1;
  localparam logic signed [3:0] ERR_ZERO     = 4'sd0;
  localparam logic signed [3:0] ERR_NEAR_POS = 4'sd1;
  localparam logic signed [3:0] ERR_FAR_POS  = 4'sd4;

  typedef struct packed {
    logic signed [1:0] dir_forward;
    logic signed [1:0] dir_side;
    logic [2:0]        prev_class;
    logic              tracking;
    logic signed [1:0] enter_dir;
    logic signed [1:0] leave_dir;
    logic signed [3:0] error_reg;
    logic              pressed;
  } track_state_t;

  function automatic logic signed [3:0] error_for_class(input logic [2:0] cls,
                                                        input logic signed [3:0] keep);
    logic signed [3:0] r;
    case (cls)
      CLS_ELEM0: r = ERR_FAR_NEG;
      CLS_ELEM1: r = ERR_NEAR_NEG;
      CLS_ELEM2: r = ERR_NEAR_POS;
      CLS_ELEM3: r = ERR_FAR_POS;
      default:   r = keep;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] sign16(input logic signed [15:0] v);
    logic signed [1:0] r;
    if (v == 16'sd0) r = DIR_ZERO;
    else if (v[15]) r = DIR_NEG;
    else r = DIR_POS;
    return r;
  endfunction

  function automatic logic signed [1:0] leave_for_mount(input logic [1:0] m);
    return (m == MOUNT_A || m == MOUNT_B) ? DIR_NEG : DIR_POS;
  endfunction

endpackage

// ----- hdl/lsct_step.sv -----
// Next-state logic for one sensor sample: classification, on/off line
// transitions, steering error and saturating crossing count. Uses lsct_pkg.
`timescale 1ns / 1ps

module lsct_step import lsct_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic [1:0]                    mount_position,
  input  track_state_t                  cur,
  input  logic signed [COUNT_WIDTH-1:0] count,
  input  logic [3:0]                    sensor_bits,
  input  logic signed [15:0]            move_forward,
  input  logic signed [15:0]            move_side,
  output track_state_t                  nxt,
  output logic signed [COUNT_WIDTH-1:0] count_next,
  output logic [2:0]                    pattern_class
);

  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  logic signed [1:0] dx;
  logic [2:0]        cls;
  logic              take;
  logic              cnt_up;
  logic              cnt_dn;

  always_comb begin
    case (mount_position)
      MOUNT_A: dx = DIR_ZERO - cur.dir_side;
      MOUNT_B: dx = DIR_ZERO - cur.dir_forward;
      MOUNT_C: dx = cur.dir_side;
      default: dx = cur.dir_forward;
    endcase
  end

  always_comb begin
    case (sensor_bits)
      4'b0000: cls = CLS_NONE;
      4'b0001: cls = CLS_ELEM0;
      4'b0010: cls = CLS_ELEM1;
      4'b0100: cls = CLS_ELEM2;
      4'b1000: cls = CLS_ELEM3;
      default: cls = (sensor_bits[0] && sensor_bits[3]) ? CLS_PRESSED : CLS_IGNORED;
    endcase
  end

  assign pattern_class = cls;

  always_comb begin
    nxt    = cur;
    take   = 1'b1;
    cnt_up = 1'b0;
    cnt_dn = 1'b0;
    if (cls <= CLS_ELEM3) nxt.pressed = 1'b0;
    else if (cls == CLS_PRESSED) nxt.pressed = 1'b1;
    nxt.dir_forward = sign16(move_forward);
    nxt.dir_side    = sign16(move_side);
    if (cls <= CLS_ELEM3 && cls != cur.prev_class) begin
      if (cls != CLS_NONE) begin
        if (!cur.tracking) begin
          if (cls == CLS_ELEM0 || cls == CLS_ELEM3) begin
            nxt.tracking  = 1'b1;
            nxt.enter_dir = (cls == CLS_ELEM0) ? DIR_NEG : DIR_POS;
            nxt.error_reg = (cls == CLS_ELEM0) ? ERR_FAR_NEG : ERR_FAR_POS;
            if (cur.leave_dir == nxt.enter_dir) begin
              cnt_up = (cls == CLS_ELEM3);
              cnt_dn = (cls == CLS_ELEM0);
            end
          end else begin
            take = 1'b0;
          end
        end else begin
          nxt.error_reg = error_for_class(cls, cur.error_reg);
        end
      end else begin
        if ((cur.prev_class == CLS_ELEM1 && dx == DIR_POS) ||
            (cur.prev_class == CLS_ELEM2 && dx == DIR_NEG))
          nxt.error_reg = ERR_ZERO;
        if (cur.prev_class == CLS_ELEM0 && dx == DIR_POS) begin
          nxt.tracking  = 1'b0;
          nxt.leave_dir = DIR_POS;
        end else if (cur.prev_class == CLS_ELEM3 && dx == DIR_NEG) begin
          nxt.tracking  = 1'b0;
          nxt.leave_dir = DIR_NEG;
        end else if (dx == DIR_ZERO) begin
          nxt.error_reg = error_for_class(cur.prev_class, cur.error_reg);
        end
      end
      if (take) nxt.prev_class = cls;
    end
  end

  always_comb begin
    count_next = count;
    if (cnt_up && count != CNT_MAX) count_next = count + CNT_ONE;
    else if (cnt_dn && count != CNT_MIN) count_next = count - CNT_ONE;
  end

endmodule

// ----- hdl/line_sensor_crossing_tracker_top.sv -----
// Top level of the line sensor crossing tracker: stream ports, input and
// result registers, tracking state. Uses lsct_pkg and lsct_step.
`timescale 1ns / 1ps

// Takes one sensor word per clock unless stalled; one result per input word.
// A word passes an input register and then the step logic into the result
// register, so its result is valid from the clock edge after the one that
// accepted it when the output is not stalled; throughput is one word per
// cycle, limited only by m_tready.
// The tracking state updates as a word moves into the result register, so the
// next word sees the new state with no bubble. The mount position
// register is written over cfg_valid/cfg_data and should only be changed
// while no word is in flight; a write also reloads the leave direction.
// No clearing pass after reset.
module line_sensor_crossing_tracker_top import lsct_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,   // mount_position
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // sensor_bits[3:0], move_forward[19:4],
                                  // move_side[35:20], zero[39:36]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata     // pattern_class[2:0], line_pressed[3],
                                  // steer_error[7:4], crossing_count[23:8],
                                  // tracking_line[24], zero[31:25]
);

  logic                    in_valid;
  logic [3:0]              in_bits;
  logic signed [15:0]      in_fwd;
  logic signed [15:0]      in_side;
  logic                    advance;

  logic [1:0]              mount_position;
  track_state_t            st;
  track_state_t            st_next;
  logic signed [COUNT_WIDTH-1:0] count;
  logic signed [COUNT_WIDTH-1:0] count_next;
  logic signed [COUNT_WIDTH+15:0] count_ext;
  logic [2:0]              cls;

  logic                    out_valid;
  logic [2:0]              out_class;
  logic                    out_pressed;
  logic signed [3:0]       out_err;
  logic [15:0]             out_count;
  logic                    out_tracking;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_bits <= s_tdata[3:0];
      in_fwd  <= s_tdata[19:4];
      in_side <= s_tdata[35:20];
    end
  end

  lsct_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step (
    .mount_position (mount_position),
    .cur            (st),
    .count          (count),
    .sensor_bits    (in_bits),
    .move_forward   (in_fwd),
    .move_side      (in_side),
    .nxt            (st_next),
    .count_next     (count_next),
    .pattern_class  (cls)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mount_position <= MOUNT_A;
      st             <= '{dir_forward: DIR_ZERO, dir_side: DIR_ZERO,
                          prev_class: CLS_NONE, tracking: 1'b0,
                          enter_dir: DIR_ZERO, leave_dir: leave_for_mount(MOUNT_A),
                          error_reg: ERR_ZERO, pressed: 1'b0};
      count          <= '0;
    end else if (cfg_valid && cfg_ready) begin
      mount_position <= cfg_data;
      st.leave_dir   <= leave_for_mount(cfg_data);
    end else if (advance && in_valid) begin
      st    <= st_next;
      count <= count_next;
    end
  end

  assign count_ext = {{16{count_next[COUNT_WIDTH-1]}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_class    <= cls;
      out_pressed  <= st_next.pressed;
      out_err      <= st_next.error_reg;
      out_count    <= count_ext[15:0];
      out_tracking <= st_next.tracking;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_tracking, out_count, out_err, out_pressed, out_class};

  a_err_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_err == ERR_FAR_NEG || out_err == ERR_NEAR_NEG ||
                  out_err == ERR_ZERO || out_err == ERR_NEAR_POS ||
                  out_err == ERR_FAR_POS))
    else $error("steering error out of set");

  a_pressed_class: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_pressed) |-> (out_class == CLS_PRESSED || out_class == CLS_IGNORED))
    else $error("pressed flag with single-element or empty pattern");

  a_enter_set: assert property (@(posedge clk) disable iff (rst)
    st.tracking |-> (st.enter_dir == DIR_NEG || st.enter_dir == DIR_POS))
    else $error("tracking without entry side");

  a_leave_set: assert property (@(posedge clk) disable iff (rst)
    (st.leave_dir == DIR_NEG || st.leave_dir == DIR_POS))
    else $error("leave direction invalid");

endmodule
